@@ design/tdres_pkg.sv @@
// shared types and constants for the tridiagonal residual norm block
package tdres_pkg;

  localparam int unsigned SumW   = 64;
  localparam int unsigned RootW  = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_DRAIN,
    ST_SQUARE,
    ST_SUM,
    ST_ROOT
  } tdres_state_e;

  typedef enum logic {
    PH_HELD,
    PH_LAST
  } tdres_phase_e;

  typedef enum logic [1:0] {
    POS_NONE,
    POS_FIRST,
    POS_MID
  } tdres_pos_e;

endpackage

@@ design/tdres_in_if.sv @@
// row request channel: coefficients, rhs, solution entry and last-row mark
interface tdres_in_if #(
  parameter int unsigned VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] lower_coef;
  logic signed [VALUE_WIDTH-1:0] main_coef;
  logic signed [VALUE_WIDTH-1:0] upper_coef;
  logic signed [VALUE_WIDTH-1:0] rhs_value;
  logic signed [VALUE_WIDTH-1:0] solution_value;
  logic                          last_row;

  modport source (
    output valid, lower_coef, main_coef, upper_coef, rhs_value, solution_value, last_row,
    input  ready
  );
  modport sink (
    input  valid, lower_coef, main_coef, upper_coef, rhs_value, solution_value, last_row,
    output ready
  );
endinterface

@@ design/tdres_out_if.sv @@
// result request channel: residual norm and overflow flag
interface tdres_out_if #(
  parameter int unsigned VALUE_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] residual_norm;
  logic                   overflow;

  modport source (
    output valid, residual_norm, overflow,
    input  ready
  );
  modport sink (
    input  valid, residual_norm, overflow,
    output ready
  );
endinterface

@@ design/tdres_mul.sv @@
// shared signed multiplier with registered product
module tdres_mul #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic signed [VALUE_WIDTH-1:0]   a_i,
  input  logic signed [VALUE_WIDTH-1:0]   b_i,
  output logic signed [2*VALUE_WIDTH-1:0] p_o
);

  logic signed [2*VALUE_WIDTH-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= (2*VALUE_WIDTH)'(a_i) * (2*VALUE_WIDTH)'(b_i);
  end

  assign p_o = p_q;

endmodule

@@ design/tdres_root.sv @@
// bit-serial integer square root of the 64-bit sum, one result bit per cycle
module tdres_root (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [tdres_pkg::SumW-1:0]  radicand_i,
  output logic                        busy_o,
  output logic [tdres_pkg::RootW-1:0] root_o
);
  import tdres_pkg::*;

  localparam logic [SumW-1:0] FirstBit = SumW'(1) << (SumW - 2);

  logic [SumW-1:0] rem_q, rem_d;
  logic [SumW-1:0] res_q, res_d;
  logic [SumW-1:0] bit_q, bit_d;
  logic [SumW-1:0] trial;
  logic            busy_q, busy_d;

  always_comb begin
    rem_d  = rem_q;
    res_d  = res_q;
    bit_d  = bit_q;
    busy_d = busy_q;
    trial  = res_q + bit_q;
    if (start_i) begin
      rem_d  = radicand_i;
      res_d  = '0;
      bit_d  = FirstBit;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (rem_q >= trial) begin
        rem_d = rem_q - trial;
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      // the step on the lowest bit pair is the last one
      if (bit_q == SumW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  assign busy_o = busy_q;
  assign root_o = res_q[RootW-1:0];

endmodule

@@ design/tridiagonal_residual_l2_norm_top.sv @@
// top level: row sequencer, residual accumulator and square sum around shared units
// a first row that is not last is only held; any other row runs 1 to 3 products
//   through the shared multiplier, then the drain, square and sum states
// a last row runs the held row and its own residual back to back, then the root
//   unit and the output register give the result
// reset clears the sequencer, row position, square sum, flag and output valid

module tridiagonal_residual_l2_norm_top #(
  parameter int unsigned VALUE_WIDTH   = 32,
  parameter int unsigned FRACTION_BITS = 24
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tdres_in_if.sink   in_i,
  tdres_out_if.source out_o
);
  import tdres_pkg::*;

  localparam int unsigned W    = VALUE_WIDTH;
  localparam int unsigned AccW = 2 * VALUE_WIDTH + 2;

  localparam logic signed [AccW-1:0] Half  = AccW'(1) << (FRACTION_BITS - 1);
  localparam logic signed [AccW-1:0] ResHi = (AccW'(1) << (W - 1)) - AccW'(1);
  localparam logic signed [AccW-1:0] ResLo = -(AccW'(1) << (W - 1));
  localparam logic [RootW-1:0]       MaxOut = RootW'((65'd1 << W) - 65'd1);

  tdres_state_e state_q, state_d;
  tdres_phase_e phase_q, phase_d;
  tdres_pos_e   pos_q, pos_d;
  logic [1:0]   idx_q, idx_d;
  logic [1:0]   last_idx;

  logic signed [AccW-1:0] acc_q, acc_d;
  logic [SumW-1:0]        sum_q, sum_d;
  logic                   sat_q, sat_d;

  // held row and the solution entry before it
  logic signed [W-1:0] held_lower_q, held_main_q, held_upper_q, held_rhs_q;
  logic signed [W-1:0] held_sol_q, older_sol_q;
  // row currently being worked on
  logic signed [W-1:0] cur_lower_q, cur_main_q, cur_upper_q, cur_rhs_q, cur_sol_q;
  logic                cur_last_q;

  logic                out_vld_q, out_vld_d;
  logic [W-1:0]        norm_q, norm_d;
  logic                ovf_q, ovf_d;

  logic signed [W-1:0]     mul_a, mul_b;
  logic signed [2*W-1:0]   prod;
  logic signed [AccW-1:0]  prod_ext, prod_rnd;
  logic signed [W-1:0]     res_clamped;
  logic                    res_sat;
  logic [SumW:0]           sum_wide;

  logic                    root_start, root_busy;
  logic [RootW-1:0]        root;
  logic                    root_big;

  logic                    in_fire, cur_load, held_from_in, held_from_cur, out_load;

  tdres_mul #(.VALUE_WIDTH(W)) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  tdres_root u_root (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (root_start),
    .radicand_i (sum_d),
    .busy_o     (root_busy),
    .root_o     (root)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;

  // round half up to the fraction grid
  assign prod_ext = AccW'(prod);
  assign prod_rnd = (prod_ext + Half) >>> FRACTION_BITS;

  always_comb begin
    if (acc_q > ResHi) begin
      res_clamped = ResHi[W-1:0];
      res_sat     = 1'b1;
    end else if (acc_q < ResLo) begin
      res_clamped = ResLo[W-1:0];
      res_sat     = 1'b1;
    end else begin
      res_clamped = acc_q[W-1:0];
      res_sat     = 1'b0;
    end
  end

  assign sum_wide = {1'b0, sum_q} + {1'b0, SumW'($unsigned(prod))};
  assign root_big = (root > MaxOut);

  always_comb begin
    if (phase_q == PH_HELD) begin
      last_idx = (pos_q == POS_MID) ? 2'd2 : 2'd1;
    end else begin
      last_idx = (pos_q != POS_NONE) ? 2'd1 : 2'd0;
    end
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == ST_SQUARE) begin
      mul_a = res_clamped;
      mul_b = res_clamped;
    end else if (phase_q == PH_HELD) begin
      case (idx_q)
        2'd0: begin
          mul_a = held_main_q;
          mul_b = held_sol_q;
        end
        2'd1: begin
          mul_a = held_upper_q;
          mul_b = cur_sol_q;
        end
        default: begin
          mul_a = held_lower_q;
          mul_b = older_sol_q;
        end
      endcase
    end else begin
      case (idx_q)
        2'd0: begin
          mul_a = cur_main_q;
          mul_b = cur_sol_q;
        end
        default: begin
          mul_a = cur_lower_q;
          mul_b = held_sol_q;
        end
      endcase
    end
  end

  always_comb begin
    state_d       = state_q;
    phase_d       = phase_q;
    pos_d         = pos_q;
    idx_d         = idx_q;
    acc_d         = acc_q;
    sum_d         = sum_q;
    sat_d         = sat_q;
    out_vld_d     = out_vld_q;
    norm_d        = norm_q;
    ovf_d         = ovf_q;
    cur_load      = 1'b0;
    held_from_in  = 1'b0;
    held_from_cur = 1'b0;
    root_start    = 1'b0;
    out_load      = 1'b0;

    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          cur_load = 1'b1;
          idx_d    = 2'd0;
          if (pos_q != POS_NONE) begin
            phase_d = PH_HELD;
            acc_d   = AccW'(held_rhs_q);
            state_d = ST_PROD;
          end else if (in_i.last_row) begin
            phase_d = PH_LAST;
            acc_d   = AccW'(in_i.rhs_value);
            state_d = ST_PROD;
          end else begin
            // first row of a system: just hold it
            held_from_in = 1'b1;
            pos_d        = POS_FIRST;
          end
        end
      end
      ST_PROD: begin
        if (idx_q != 2'd0) begin
          acc_d = acc_q - prod_rnd;
        end
        if (idx_q == last_idx) begin
          state_d = ST_DRAIN;
        end else begin
          idx_d = idx_q + 2'd1;
        end
      end
      ST_DRAIN: begin
        acc_d   = acc_q - prod_rnd;
        state_d = ST_SQUARE;
      end
      ST_SQUARE: begin
        if (res_sat) begin
          sat_d = 1'b1;
        end
        state_d = ST_SUM;
      end
      ST_SUM: begin
        if (sum_wide[SumW]) begin
          sum_d = '1;
          sat_d = 1'b1;
        end else begin
          sum_d = sum_wide[SumW-1:0];
        end
        if (phase_q == PH_LAST) begin
          root_start = 1'b1;
          state_d    = ST_ROOT;
        end else if (cur_last_q) begin
          phase_d = PH_LAST;
          idx_d   = 2'd0;
          acc_d   = AccW'(cur_rhs_q);
          state_d = ST_PROD;
        end else begin
          held_from_cur = 1'b1;
          pos_d         = POS_MID;
          state_d       = ST_IDLE;
        end
      end
      ST_ROOT: begin
        // wait for the root and a free output slot
        if (!root_busy && (!out_vld_q || out_o.ready)) begin
          out_load  = 1'b1;
          out_vld_d = 1'b1;
          norm_d    = root_big ? MaxOut[W-1:0] : root[W-1:0];
          ovf_d     = sat_q || root_big;
          pos_d     = POS_NONE;
          sum_d     = '0;
          sat_d     = 1'b0;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      phase_q   <= PH_HELD;
      pos_q     <= POS_NONE;
      idx_q     <= 2'd0;
      sum_q     <= '0;
      sat_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      idx_q     <= idx_d;
      sum_q     <= sum_d;
      sat_q     <= sat_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (cur_load) begin
      cur_lower_q <= in_i.lower_coef;
      cur_main_q  <= in_i.main_coef;
      cur_upper_q <= in_i.upper_coef;
      cur_rhs_q   <= in_i.rhs_value;
      cur_sol_q   <= in_i.solution_value;
      cur_last_q  <= in_i.last_row;
    end
    if (held_from_in) begin
      older_sol_q  <= held_sol_q;
      held_lower_q <= in_i.lower_coef;
      held_main_q  <= in_i.main_coef;
      held_upper_q <= in_i.upper_coef;
      held_rhs_q   <= in_i.rhs_value;
      held_sol_q   <= in_i.solution_value;
    end else if (held_from_cur) begin
      older_sol_q  <= held_sol_q;
      held_lower_q <= cur_lower_q;
      held_main_q  <= cur_main_q;
      held_upper_q <= cur_upper_q;
      held_rhs_q   <= cur_rhs_q;
      held_sol_q   <= cur_sol_q;
    end
    if (out_load) begin
      norm_q <= norm_d;
      ovf_q  <= ovf_d;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.residual_norm = norm_q;
  assign out_o.overflow      = ovf_q;

endmodule
